@@ src/pcv_pkg.sv @@
package pcv_pkg;

  // field widths fixed by the pixel format and the result format
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned TOTAL_W = 19;
  localparam int unsigned VOTES_W = 19;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // lead margins, one bit wider than a channel so sums cannot wrap
  localparam logic [LEVEL_W:0] RED_OVER_GREEN  = 9'd45;
  localparam logic [LEVEL_W:0] RED_OVER_BLUE   = 9'd30;
  localparam logic [LEVEL_W:0] GREEN_OVER_RED  = 9'd30;
  localparam logic [LEVEL_W:0] GREEN_OVER_BLUE = 9'd20;
  localparam logic [LEVEL_W:0] BLUE_OVER_GREEN = 9'd50;
  localparam logic [LEVEL_W:0] BLUE_OVER_RED   = 9'd50;

  // register reset values
  localparam logic [LEVEL_W-1:0] DARK_RESET      = 8'd20;
  localparam logic [LEVEL_W-1:0] BRIGHT_RESET    = 8'd135;
  localparam logic [VOTES_W-1:0] MIN_VOTES_RESET = 19'd6144;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_DARK      = 2'd0;
  localparam logic [1:0] REG_BRIGHT    = 2'd1;
  localparam logic [1:0] REG_MIN_VOTES = 2'd2;

  typedef enum logic [1:0] {
    CLS_RED   = 2'd0,
    CLS_GREEN = 2'd1,
    CLS_BLUE  = 2'd2,
    CLS_DEAD  = 2'd3
  } pcv_class_e;

  typedef enum logic [2:0] {
    COL_RED   = 3'd0,
    COL_GREEN = 3'd1,
    COL_BLUE  = 3'd2,
    COL_UNDEF = 3'd3,
    COL_NONE  = 3'd4
  } pcv_colour_e;

  // pixel as carried between pipeline stages
  typedef struct packed {
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
  } pcv_pixel_t;

endpackage

@@ src/pcv_classify.sv @@
module pcv_classify
  import pcv_pkg::*;
(
  input  pcv_pixel_t         pixel_i,
  input  logic [LEVEL_W-1:0] dark_limit_i,
  input  logic [LEVEL_W-1:0] bright_limit_i,
  output pcv_class_e         class_o
);

  logic [LEVEL_W:0] r_w, g_w, b_w;
  logic             is_dark, is_bright;
  logic             red_lead, green_lead, blue_lead;

  // widen channels so margin sums stay exact
  assign r_w = {1'b0, pixel_i.red};
  assign g_w = {1'b0, pixel_i.green};
  assign b_w = {1'b0, pixel_i.blue};

  // dead by exposure
  assign is_dark   = (pixel_i.red < dark_limit_i) && (pixel_i.green < dark_limit_i)
                     && (pixel_i.blue < dark_limit_i);
  assign is_bright = (pixel_i.red > bright_limit_i) && (pixel_i.green > bright_limit_i)
                     && (pixel_i.blue > bright_limit_i);

  // channel lead tests
  assign red_lead   = (r_w > g_w + RED_OVER_GREEN) && (r_w > b_w + RED_OVER_BLUE);
  assign green_lead = (g_w > r_w + GREEN_OVER_RED) && (g_w > b_w + GREEN_OVER_BLUE);
  assign blue_lead  = (b_w > g_w + BLUE_OVER_GREEN) && (b_w > r_w + BLUE_OVER_RED);

  // priority: exposure, red, green, blue, else dead
  always_comb begin
    if (is_dark || is_bright) begin
      class_o = CLS_DEAD;
    end else if (red_lead) begin
      class_o = CLS_RED;
    end else if (green_lead) begin
      class_o = CLS_GREEN;
    end else if (blue_lead) begin
      class_o = CLS_BLUE;
    end else begin
      class_o = CLS_DEAD;
    end
  end

endmodule

@@ src/pixel_colour_vote_classifier.sv @@
// Pixel colour vote classifier.
// Input channel: one BGR pixel word per accepted cycle (in_valid_i high,
// in_stall_o low), frame_end_i set on the last pixel of a frame.
// Output channel: one result word per pixel, in order, taken when out_valid_o
// is high and out_stall_i is low. pixel_class_o is always meaningful; on a
// frame-end word frame_done_o is set and frame_colour_o plus the four totals
// carry the frame verdict and counts (this pixel included), else they are 0.
// From acceptance a pixel passes the input, class and result registers;
// throughput is one pixel per cycle while the receiver does not stall. The
// per-frame vote counters update as a word enters the result register and
// clear after a frame-end word. When the receiver stalls, the result holds
// and the pipeline keeps filling its empty stages; in_stall_o rises once all
// three stages are occupied. Reset empties the pipeline, clears the counters
// and loads the default limits (dark 20, bright 135, min votes 6144). Limits
// are written over the APB port at byte addresses 0, 4 and 8; the user must
// do so only while the block is idle, which the block does not enforce.
module pixel_colour_vote_classifier
  import pcv_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 19
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // pixel in
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [LEVEL_W-1:0]  blue_level_i,
  input  logic [LEVEL_W-1:0]  green_level_i,
  input  logic [LEVEL_W-1:0]  red_level_i,
  input  logic                frame_end_i,
  // result out
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          pixel_class_o,
  output logic                frame_done_o,
  output logic [2:0]          frame_colour_o,
  output logic [TOTAL_W-1:0]  red_total_o,
  output logic [TOTAL_W-1:0]  green_total_o,
  output logic [TOTAL_W-1:0]  blue_total_o,
  output logic [TOTAL_W-1:0]  dead_total_o
);

  localparam int unsigned SUM_W = COUNT_BITS + 2;
  localparam int unsigned CMP_W = (SUM_W > VOTES_W) ? SUM_W : VOTES_W;

  // config registers
  logic [LEVEL_W-1:0] dark_limit_q, bright_limit_q;
  logic [VOTES_W-1:0] min_votes_q;
  logic               cfg_wr;

  // pipeline stages
  logic       s1_valid_q, s2_valid_q, out_valid_q;
  pcv_pixel_t s1_pixel_q;
  logic       s1_last_q, s2_last_q;
  pcv_class_e s1_class, s2_class_q;
  logic       out_free, s2_free, s1_free, s2_adv, s1_adv;

  // vote counters
  logic [COUNT_BITS-1:0] red_cnt_q, green_cnt_q, blue_cnt_q, dead_cnt_q;
  logic [COUNT_BITS-1:0] red_cnt_d, green_cnt_d, blue_cnt_d, dead_cnt_d;
  logic [CMP_W-1:0]      red_ext, green_ext, blue_ext, dead_ext, vote_sum, min_ext;
  pcv_colour_e           colour_d;

  // result register
  pcv_class_e         res_class_q;
  logic               res_done_q;
  logic [2:0]         res_colour_q;
  logic [TOTAL_W-1:0] res_red_q, res_green_q, res_blue_q, res_dead_q;

  // apb write and read
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_limit_q   <= DARK_RESET;
      bright_limit_q <= BRIGHT_RESET;
      min_votes_q    <= MIN_VOTES_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DARK:      dark_limit_q   <= pwdata[LEVEL_W-1:0];
        REG_BRIGHT:    bright_limit_q <= pwdata[LEVEL_W-1:0];
        REG_MIN_VOTES: min_votes_q    <= pwdata[VOTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DARK:      prdata = DATA_W'(dark_limit_q);
      REG_BRIGHT:    prdata = DATA_W'(bright_limit_q);
      REG_MIN_VOTES: prdata = DATA_W'(min_votes_q);
      default:       prdata = '0;
    endcase
  end

  // stage flow control: a stage loads when empty or when it drains this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_adv     = s2_valid_q && out_free;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_adv     = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_stall_o = !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free)  s1_valid_q  <= in_valid_i;
      if (s2_free)  s2_valid_q  <= s1_valid_q;
      if (out_free) out_valid_q <= s2_valid_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_free) begin
      s1_pixel_q <= '{blue: blue_level_i, green: green_level_i, red: red_level_i};
      s1_last_q  <= frame_end_i;
    end
  end

  // classify into the class register
  pcv_classify u_classify (
    .pixel_i        (s1_pixel_q),
    .dark_limit_i   (dark_limit_q),
    .bright_limit_i (bright_limit_q),
    .class_o        (s1_class)
  );

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_class_q <= s1_class;
      s2_last_q  <= s1_last_q;
    end
  end

  // saturating counts including the current pixel
  always_comb begin
    red_cnt_d   = red_cnt_q;
    green_cnt_d = green_cnt_q;
    blue_cnt_d  = blue_cnt_q;
    dead_cnt_d  = dead_cnt_q;
    case (s2_class_q)
      CLS_RED:   if (red_cnt_q != '1) red_cnt_d = red_cnt_q + 1'b1;
      CLS_GREEN: if (green_cnt_q != '1) green_cnt_d = green_cnt_q + 1'b1;
      CLS_BLUE:  if (blue_cnt_q != '1) blue_cnt_d = blue_cnt_q + 1'b1;
      default:   if (dead_cnt_q != '1) dead_cnt_d = dead_cnt_q + 1'b1;
    endcase
  end

  assign red_ext   = CMP_W'(red_cnt_d);
  assign green_ext = CMP_W'(green_cnt_d);
  assign blue_ext  = CMP_W'(blue_cnt_d);
  assign dead_ext  = CMP_W'(dead_cnt_d);
  assign vote_sum  = red_ext + green_ext + blue_ext;
  assign min_ext   = CMP_W'(min_votes_q);

  // frame verdict
  always_comb begin
    if (vote_sum <= min_ext) begin
      colour_d = COL_UNDEF;
    end else if (red_cnt_d > blue_cnt_d && red_cnt_d > green_cnt_d) begin
      colour_d = COL_RED;
    end else if (green_cnt_d > blue_cnt_d && green_cnt_d > red_cnt_d) begin
      colour_d = COL_GREEN;
    end else if (blue_cnt_d > green_cnt_d && blue_cnt_d > red_cnt_d) begin
      colour_d = COL_BLUE;
    end else begin
      colour_d = COL_NONE;
    end
  end

  // counters advance as a word enters the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_cnt_q   <= '0;
      green_cnt_q <= '0;
      blue_cnt_q  <= '0;
      dead_cnt_q  <= '0;
    end else if (s2_adv) begin
      if (s2_last_q) begin
        red_cnt_q   <= '0;
        green_cnt_q <= '0;
        blue_cnt_q  <= '0;
        dead_cnt_q  <= '0;
      end else begin
        red_cnt_q   <= red_cnt_d;
        green_cnt_q <= green_cnt_d;
        blue_cnt_q  <= blue_cnt_d;
        dead_cnt_q  <= dead_cnt_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      res_class_q <= s2_class_q;
      res_done_q  <= s2_last_q;
      if (s2_last_q) begin
        res_colour_q <= colour_d;
        res_red_q    <= red_ext[TOTAL_W-1:0];
        res_green_q  <= green_ext[TOTAL_W-1:0];
        res_blue_q   <= blue_ext[TOTAL_W-1:0];
        res_dead_q   <= dead_ext[TOTAL_W-1:0];
      end else begin
        res_colour_q <= '0;
        res_red_q    <= '0;
        res_green_q  <= '0;
        res_blue_q   <= '0;
        res_dead_q   <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_class_o  = res_class_q;
  assign frame_done_o   = res_done_q;
  assign frame_colour_o = res_colour_q;
  assign red_total_o    = res_red_q;
  assign green_total_o  = res_green_q;
  assign blue_total_o   = res_blue_q;
  assign dead_total_o   = res_dead_q;

endmodule
